@@ hw/rtl/r64enc_pkg.sv @@
// Shared types and constants for the radix-64 frame encoder.
// Used by the front, queue and back modules and the top level; no dependencies.
package r64enc_pkg;

    localparam logic [7:0] CH_START     = 8'h23;  // '#'
    localparam logic [7:0] CH_OFFSET    = 8'h3D;  // '='
    localparam logic [7:0] CH_END       = 8'h0D;  // carriage return
    localparam logic [7:0] CH_ADDR_BASE = 8'h61;  // 'a'

    localparam int unsigned SUM_W = 12;

    // Configuration register indexes.
    localparam logic [7:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [7:0] REG_COMMAND_CODE   = 8'd1;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic       hdr;    // emit the three header characters first
        logic       chunk;  // emit four characters for b0..b2
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       tail;   // emit checksum and carriage return last
    } t_cmd;

    // Back-end sequencer steps. ST_ENTRY means "first step of the head entry".
    typedef enum logic [3:0] {
        ST_ENTRY,
        ST_H0, ST_H1, ST_H2,
        ST_C0, ST_C1, ST_C2, ST_C3,
        ST_T0, ST_T1, ST_T2
    } t_step;

endpackage

@@ hw/rtl/r64enc_front.sv @@
// Front end of the radix-64 frame encoder: accepts payload words and groups them
// into chunks and frame events. Depends on r64enc_pkg.
module r64enc_front
    import r64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic        r_in_frame, n_in_frame;
    logic [1:0]  r_fill, n_fill;
    logic [15:0] r_held, n_held;

    logic        accept;
    logic [1:0]  fill_eff;
    logic [15:0] held_eff;
    t_cmd        cmd;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // A new frame starts with an empty chunk.
        fill_eff   = r_in_frame ? r_fill : 2'd0;
        held_eff   = r_in_frame ? r_held : 16'h0000;
        cmd        = '0;
        cmd.hdr    = !r_in_frame;
        cmd.tail   = i_last_byte;
        n_in_frame = r_in_frame;
        n_fill     = r_fill;
        n_held     = r_held;

        unique case (fill_eff)
            2'd2: begin
                cmd.chunk = 1'b1;
                cmd.b0    = held_eff[15:8];
                cmd.b1    = held_eff[7:0];
                cmd.b2    = i_data_byte;
                n_fill    = 2'd0;
                n_held    = 16'h0000;
            end
            2'd1: begin
                n_fill    = 2'd2;
                n_held    = {held_eff[15:8], i_data_byte};
                // Final byte completes a two-byte partial chunk.
                cmd.chunk = i_last_byte;
                cmd.b0    = held_eff[15:8];
                cmd.b1    = i_data_byte;
                cmd.b2    = 8'h00;
            end
            default: begin
                n_fill    = 2'd1;
                n_held    = {i_data_byte, 8'h00};
                cmd.chunk = i_last_byte;
                cmd.b0    = i_data_byte;
                cmd.b1    = 8'h00;
                cmd.b2    = 8'h00;
            end
        endcase

        n_in_frame = 1'b1;
        if (i_last_byte) begin
            n_in_frame = 1'b0;
            n_fill     = 2'd0;
            n_held     = 16'h0000;
        end
    end

    assign o_push = accept && (cmd.hdr || cmd.chunk || cmd.tail);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fill     <= 2'd0;
            r_held     <= 16'h0000;
        end else if (accept) begin
            r_in_frame <= n_in_frame;
            r_fill     <= n_fill;
            r_held     <= n_held;
        end
    end

endmodule

@@ hw/rtl/r64enc_queue.sv @@
// Small command queue between the front and back of the radix-64 frame encoder.
// Depends on r64enc_pkg for the command type.
module r64enc_queue
    import r64enc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/r64enc_back.sv @@
// Back end of the radix-64 frame encoder: steps through each queued command,
// one character per cycle while the output is free or accepted,
// keeps the checksum and drives the output register. Depends on r64enc_pkg.
module r64enc_back
    import r64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    input  logic [7:0] i_device_address,
    input  logic [7:0] i_command_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_frame_end
);

    t_step            r_step, n_step;
    t_step            step;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_valid;
    logic [7:0]       r_char;
    logic             r_end;
    logic             advance;
    logic [7:0]       ch;
    logic             ch_end;
    logic             ch_summed;

    assign advance = !i_empty && (!r_valid || i_ready);

    // Next step and queue pop.
    always_comb begin
        priority if (r_step != ST_ENTRY) begin
            step = r_step;
        end else if (i_head.hdr) begin
            step = ST_H0;
        end else if (i_head.chunk) begin
            step = ST_C0;
        end else begin
            step = ST_T0;
        end

        n_step = r_step;
        o_pop  = 1'b0;
        if (advance) begin
            unique case (step)
                ST_H0: n_step = ST_H1;
                ST_H1: n_step = ST_H2;
                ST_H2: begin
                    priority if (i_head.chunk) begin
                        n_step = ST_C0;
                    end else if (i_head.tail) begin
                        n_step = ST_T0;
                    end else begin
                        n_step = ST_ENTRY;
                        o_pop  = 1'b1;
                    end
                end
                ST_C0: n_step = ST_C1;
                ST_C1: n_step = ST_C2;
                ST_C2: n_step = ST_C3;
                ST_C3: begin
                    if (i_head.tail) begin
                        n_step = ST_T0;
                    end else begin
                        n_step = ST_ENTRY;
                        o_pop  = 1'b1;
                    end
                end
                ST_T0: n_step = ST_T1;
                ST_T1: n_step = ST_T2;
                ST_T2: begin
                    n_step = ST_ENTRY;
                    o_pop  = 1'b1;
                end
                default: n_step = ST_ENTRY;
            endcase
        end
    end

    // Character for the current step.
    always_comb begin
        ch        = 8'h00;
        ch_end    = 1'b0;
        ch_summed = 1'b1;
        unique case (step)
            ST_H0: ch = CH_START;
            ST_H1: ch = CH_ADDR_BASE + i_device_address;
            ST_H2: ch = i_command_code;
            ST_C0: ch = CH_OFFSET + {2'b00, i_head.b0[7:2]};
            ST_C1: ch = CH_OFFSET + {2'b00, i_head.b0[1:0], i_head.b1[7:4]};
            ST_C2: ch = CH_OFFSET + {2'b00, i_head.b1[3:0], i_head.b2[7:6]};
            ST_C3: ch = CH_OFFSET + {2'b00, i_head.b2[5:0]};
            ST_T0: begin
                ch        = CH_OFFSET + {2'b00, r_sum[11:6]};
                ch_summed = 1'b0;
            end
            ST_T1: begin
                ch        = CH_OFFSET + {2'b00, r_sum[5:0]};
                ch_summed = 1'b0;
            end
            ST_T2: begin
                ch        = CH_END;
                ch_end    = 1'b1;
                ch_summed = 1'b0;
            end
            default: ch_summed = 1'b0;
        endcase

        // The checksum restarts with the frame's first character.
        if (step == ST_H0) begin
            n_sum = {{(SUM_W-8){1'b0}}, CH_START};
        end else if (ch_summed) begin
            n_sum = r_sum + {{(SUM_W-8){1'b0}}, ch};
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_ENTRY;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (advance) begin
                r_sum   <= n_sum;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char <= ch;
            r_end  <= ch_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_frame_end = r_end;

endmodule

@@ hw/rtl/radix64_frame_encoder.sv @@
// Top level of the radix-64 frame encoder: configuration registers and the
// front, queue and back instances. Depends on r64enc_pkg and the r64enc_* modules.
//
//   channel   | direction | handshake          | word contents (low bit up)
//   ----------+-----------+--------------------+-------------------------------------
//   s_*       | in        | s_tvalid/s_tready  | tdata: data_byte[7:0]; tlast: last_byte
//   m_*       | out       | m_tvalid/m_tready  | tdata: out_char[7:0]; tlast: frame_end
//   i_cfg_*   | in        | valid/o_cfg_ready  | index[7:0], data[7:0]
//
// The back end emits one character per cycle while a command is queued and the output
// is accepted, which sets the sustained rate: a long frame costs four output characters
// per three payload words, plus three header and three trailer characters per frame.
// The front accepts one word per cycle as long as the command queue (QUEUE_DEPTH
// entries) has room; a word that only fills a chunk takes no queue slot. The output
// register holds one character; while it waits unaccepted the back stalls, and the
// queue lets the front keep taking words until it fills. Reset is synchronous and
// active low; it empties the queue, drops the output word and restores the register
// defaults. Configuration writes are taken at any time.
module radix64_frame_encoder
    import r64enc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_char
    output logic       m_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_device_address;
    logic [7:0] r_command_code;

    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Registers are always writable; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= 8'd1;
            r_command_code   <= 8'd73;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DEVICE_ADDRESS) begin
                r_device_address <= i_cfg_data;
            end
            if (i_cfg_index == REG_COMMAND_CODE) begin
                r_command_code <= i_cfg_data;
            end
        end
    end

    // The front decides per word whether a header, a chunk and a trailer are due.
    r64enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_data_byte  (s_tdata),
        .i_last_byte  (s_tlast),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    r64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    // The back turns each command into characters and keeps the frame checksum.
    r64enc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_cmd),
        .i_empty          (queue_empty),
        .o_pop            (pop),
        .i_device_address (r_device_address),
        .i_command_code   (r_command_code),
        .o_valid          (m_tvalid),
        .i_ready          (m_tready),
        .o_out_char       (m_tdata),
        .o_frame_end      (m_tlast)
    );

endmodule

@@ hw/rtl/r64enc_checker.sv @@
// Port-level checks for the radix-64 frame encoder, bound to the top level.
// Depends only on the top level's ports.
module r64enc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       o_cfg_ready
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // The frame always closes on a carriage return.
    a_end_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tdata == 8'h0D)
        else $error("frame end without carriage return");

    // Reset drops any pending output word.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // The configuration port never stalls out of reset.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind radix64_frame_encoder r64enc_checker u_r64enc_checker (.*);
